// File: rtl/joystick_axis_calibrate_core_assert.svh
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_core assertion macros
// shared property forms for the checker, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CALIBRATE_CORE_ASSERT_SVH
`define JOYSTICK_AXIS_CALIBRATE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define JAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// widths, constants, types and helpers of the joystick axis calibration block
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int REG_W       = 12;
    localparam int AXIS_W      = 16;
    localparam int LEVEL_W     = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAD_W     = M_TDATA_W - AXIS_W - LEVEL_W;
    localparam int CFG_IDX_W   = 3;

    // output scale
    localparam int OUT_MIN     = -32767;
    localparam int OUT_CENTER  = 0;
    localparam int OUT_MAX     = 32767;
    localparam int FIELD_LIMIT = 32767;
    localparam int BOUND_LO    = (OUT_MIN > -FIELD_LIMIT) ? OUT_MIN : -FIELD_LIMIT;
    localparam int BOUND_HI    = (OUT_MAX < FIELD_LIMIT) ? OUT_MAX : FIELD_LIMIT;
    localparam int SPAN_LO     = OUT_CENTER - OUT_MIN;
    localparam int SPAN_HI     = OUT_MAX - OUT_CENTER;

    // datapath widths
    localparam int DIFF_W      = REG_W + 1;
    localparam int SPAN_W      = 17;
    localparam int PROD_W      = DIFF_W + SPAN_W;
    localparam int NUM_W       = 28;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = $clog2(NUM_W);

    localparam logic [SAMPLE_W-1:0] PREV_RST = SAMPLE_W'(1);

    localparam logic signed [LEVEL_W-1:0] LVL_ZERO = 2'sb00;
    localparam logic signed [LEVEL_W-1:0] LVL_POS  = 2'sb01;
    localparam logic signed [LEVEL_W-1:0] LVL_NEG  = 2'sb11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_MIN     = 3'd0,
        CFG_CAL_MAX     = 3'd1,
        CFG_CAL_CENTER  = 3'd2,
        CFG_DIG_LOWER   = 3'd3,
        CFG_DIG_UPPER   = 3'd4,
        CFG_OUTPUT_MODE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [REG_W-1:0] cal_min;
        logic [REG_W-1:0] cal_max;
        logic [REG_W-1:0] cal_center;
        logic [REG_W-1:0] dig_lower;
        logic [REG_W-1:0] dig_upper;
        logic             output_mode;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        cal_min:     12'd0,
        cal_max:     12'd4095,
        cal_center:  12'd2048,
        dig_lower:   12'd1024,
        dig_upper:   12'd3072,
        output_mode: 1'b0
    };

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [REG_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    // clamp to the output range and to the field range
    function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        r = v;
        if (v < signed'(VAL_W'(BOUND_LO)))
        begin
            r = signed'(VAL_W'(BOUND_LO));
        end
        if (v > signed'(VAL_W'(BOUND_HI)))
        begin
            r = signed'(VAL_W'(BOUND_HI));
        end
        return r[AXIS_W-1:0];
    endfunction

endpackage

// File: rtl/jac_cfg.sv
// ----------------------------------------------------------------------------
// jac_cfg
// configuration register file, one register written per request
// ----------------------------------------------------------------------------
module jac_cfg
    import jac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CAL_MIN:     cfg_next.cal_min     = cfg_data;
                CFG_CAL_MAX:     cfg_next.cal_max     = cfg_data;
                CFG_CAL_CENTER:  cfg_next.cal_center  = cfg_data;
                CFG_DIG_LOWER:   cfg_next.dig_lower   = cfg_data;
                CFG_DIG_UPPER:   cfg_next.dig_upper   = cfg_data;
                CFG_OUTPUT_MODE: cfg_next.output_mode = cfg_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/jac_sdiv.sv
// ----------------------------------------------------------------------------
// jac_sdiv
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module jac_sdiv
    import jac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [REG_W-1:0] rem_reg;
    logic [REG_W-1:0] rem_next;
    logic [REG_W-1:0] den_reg;
    logic [REG_W-1:0] den_next;
    logic [REG_W:0]   shifted;
    logic [REG_W:0]   trial;
    logic             fits;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        // dividend bits leave the top of quo_reg as quotient bits enter below
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? trial[REG_W-1:0] : shifted[REG_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// File: rtl/joystick_axis_calibrate_core.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_core
// calibrated axis value and three-level state from one raw axis sample
// ----------------------------------------------------------------------------
// s_tvalid/s_tready/s_tdata carry one raw sample per request; m_* return one
// result per sample: changed flag in m_tuser, axis value and digital state
// in m_tdata. cfg_valid/cfg_ready/cfg_index/cfg_data write one calibration
// register per request; write only while no sample is in flight.
// One sample is worked on at a time. In linear mode with a nonzero segment
// the sample goes through the 28-step serial divider, which produces one
// quotient bit per cycle. Digital mode, a sample at the center and a
// zero-width segment skip the divider.
// The result sits in an output register, so a new sample is accepted while
// the receiver stalls; a finished result then waits until the register is
// free. Reset loads the calibration defaults, sets the previous sample to
// one and empties the output register.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_core
    import jac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] raw_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] axis_value, [17:16] digital_state
    output logic                 m_tuser,   // [0] changed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t                      state_reg;
    state_t                      state_next;
    logic [SAMPLE_W-1:0]         prev_reg;
    logic [SAMPLE_W-1:0]         prev_next;
    logic                        m_tvalid_reg;
    logic                        m_tvalid_next;

    logic [SAMPLE_W-1:0]         samp_reg;
    logic [SAMPLE_W-1:0]         samp_next;
    logic                        changed_reg;
    logic                        changed_next;
    logic signed [LEVEL_W-1:0]   level_reg;
    logic signed [LEVEL_W-1:0]   level_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic                        first_reg;
    logic                        first_next;
    logic signed [AXIS_W-1:0]    axis_reg;
    logic signed [AXIS_W-1:0]    axis_next;
    logic                        m_changed_reg;
    logic                        m_changed_next;
    logic signed [AXIS_W-1:0]    m_axis_reg;
    logic signed [AXIS_W-1:0]    m_axis_next;
    logic signed [LEVEL_W-1:0]   m_level_reg;
    logic signed [LEVEL_W-1:0]   m_level_next;

    logic                        accept;
    logic                        out_free;
    logic                        inv;
    logic                        at_center;
    logic                        first_seg;
    logic [REG_W-1:0]            in_lo;
    logic [REG_W-1:0]            in_hi;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [DIFF_W-1:0]    span_den;
    logic signed [PROD_W-1:0]    span;
    logic signed [PROD_W-1:0]    prod;
    logic [NUM_W-1:0]            num_mag;
    logic [REG_W-1:0]            den_mag;
    logic signed [LEVEL_W-1:0]   level_now;
    logic signed [VAL_W-1:0]     dig_val;
    logic signed [VAL_W-1:0]     quo_val;
    logic signed [VAL_W-1:0]     seg_val;

    function automatic logic signed [LEVEL_W-1:0] dig_level(
        input logic [SAMPLE_W-1:0] s,
        input logic [REG_W-1:0]    lo,
        input logic [REG_W-1:0]    up
    );
        logic flip;
        logic signed [LEVEL_W-1:0] r;
        flip = lo > up;
        r    = LVL_ZERO;
        if ((s > lo && s < up) || (s > up && s < lo))
        begin
            r = LVL_ZERO;
        end
        else if (s > up)
        begin
            r = flip ? LVL_NEG : LVL_POS;
        end
        else if (s < lo)
        begin
            r = flip ? LVL_POS : LVL_NEG;
        end
        return r;
    endfunction

    jac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jac_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_changed_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_level_reg, m_axis_reg};

    // segment setup from the held sample
    always_comb
    begin
        inv       = cfg.cal_min > cfg.cal_max;
        at_center = samp_reg == cfg.cal_center;
        first_seg = (samp_reg < cfg.cal_center && !inv) ||
                    (samp_reg > cfg.cal_center && inv);
        in_lo     = first_seg ? cfg.cal_min : cfg.cal_center;
        in_hi     = first_seg ? cfg.cal_center : cfg.cal_max;
        diff      = signed'({1'b0, samp_reg}) - signed'({1'b0, in_lo});
        span_den  = signed'({1'b0, in_hi}) - signed'({1'b0, in_lo});
        span      = first_seg ? signed'(PROD_W'(SPAN_LO)) : signed'(PROD_W'(SPAN_HI));
        prod      = PROD_W'(diff) * span;
        num_mag   = prod[PROD_W-1] ? NUM_W'(-prod) : NUM_W'(prod);
        den_mag   = span_den[DIFF_W-1] ? REG_W'(-span_den) : REG_W'(span_den);
        level_now = dig_level(samp_reg, cfg.dig_lower, cfg.dig_upper);
        if (level_now == LVL_POS)
        begin
            dig_val = signed'(VAL_W'(OUT_MAX));
        end
        else if (level_now == LVL_NEG)
        begin
            dig_val = signed'(VAL_W'(-OUT_MAX));
        end
        else
        begin
            dig_val = '0;
        end
        quo_val = neg_reg ? -signed'(VAL_W'(div_rsp.quotient))
                          : signed'(VAL_W'(div_rsp.quotient));
        seg_val = quo_val + (first_reg ? signed'(VAL_W'(OUT_MIN))
                                       : signed'(VAL_W'(OUT_CENTER)));
    end

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        m_tvalid_next  = m_tvalid_reg;
        samp_next      = samp_reg;
        changed_next   = changed_reg;
        level_next     = level_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        axis_next      = axis_reg;
        m_changed_next = m_changed_reg;
        m_axis_next    = m_axis_reg;
        m_level_next   = m_level_reg;
        div_req.start  = 1'b0;
        div_req.num    = num_mag;
        div_req.den    = den_mag;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    samp_next    = s_tdata[SAMPLE_W-1:0];
                    changed_next = s_tdata[SAMPLE_W-1:0] != prev_reg;
                    prev_next    = s_tdata[SAMPLE_W-1:0];
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                level_next = level_now;
                neg_next   = prod[PROD_W-1] ^ span_den[DIFF_W-1];
                first_next = first_seg;
                if (cfg.output_mode)
                begin
                    axis_next  = sat_axis(dig_val);
                    state_next = ST_DONE;
                end
                else if (at_center || span_den == '0)
                begin
                    axis_next  = sat_axis(signed'(VAL_W'(OUT_CENTER)));
                    state_next = ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    axis_next  = sat_axis(seg_val);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_changed_next = changed_reg;
                    m_axis_next    = axis_reg;
                    m_level_next   = level_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_reg     <= PREV_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        changed_reg   <= changed_next;
        level_reg     <= level_next;
        neg_reg       <= neg_next;
        first_reg     <= first_next;
        axis_reg      <= axis_next;
        m_changed_reg <= m_changed_next;
        m_axis_reg    <= m_axis_next;
        m_level_reg   <= m_level_next;
    end

endmodule

// File: rtl/jac_checker.sv
// ----------------------------------------------------------------------------
// jac_checker
// port-level checks of the joystick axis calibration block
// ----------------------------------------------------------------------------
`include "joystick_axis_calibrate_core_assert.svh"

module jac_checker
    import jac_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    `JAC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `JAC_ASSERT_NEXT(a_one_sample, s_tvalid && s_tready, !s_tready, "second sample taken while one is in flight")
    `JAC_ASSERT_NOW(a_level_code, m_tvalid, m_tdata[AXIS_W+LEVEL_W-1:AXIS_W] != 2'b10, "digital state out of range")
    `JAC_ASSERT_NOW(a_axis_range, m_tvalid, m_tdata[AXIS_W-1:0] != 16'h8000, "axis value below saturation bound")

endmodule

bind joystick_axis_calibrate_core jac_checker u_jac_checker (.*);

// File: tb/joystick_axis_calibrate_core_test.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_core_test
// self-checking bench for the joystick axis calibration core
// ----------------------------------------------------------------------------
// A directed table covers reset defaults, the sample extremes, the center,
// inverted axes, zero-width segments, inverted and equal thresholds and
// saturation. Random phases with a fresh calibration each follow. Every
// accepted sample is run through a local model, and every returned reading
// is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_core_test;
    import jac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_SAMPLES  = 85;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SAMPLE_TOP     = (1 << SAMPLE_W) - 1;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                       changed;
        logic signed [AXIS_W-1:0]   axis;
        logic signed [LEVEL_W-1:0]  level;
    } reading_t;

    typedef struct {
        cfg_t                  setting;
        logic [SAMPLE_W-1:0]   sample;
        bit                    typed;
        reading_t              want;
    } vector_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [11:0] raw_sample
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [15:0] axis_value, [17:16] digital_state
    logic                 m_tuser;     // [0] changed
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    cfg_t                 cal;
    logic [SAMPLE_W-1:0]  last_sample;
    reading_t             pending_readings[$];
    vector_t              directed[$];
    bit                   no_idle;
    int                   mismatches;
    int                   samples_sent;
    int                   readings_checked;
    int                   settings_loaded;
    int                   idle_cycles;

    joystick_axis_calibrate_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint segment(input longint x, input longint in_lo,
                                       input longint in_hi, input longint out_lo,
                                       input longint out_hi);
        if (in_hi == in_lo)
        begin
            return OUT_CENTER;
        end
        return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    endfunction

    // expected reading for one sample; advances the previous-sample copy
    function automatic reading_t calibrate(input logic [SAMPLE_W-1:0] s);
        reading_t r;
        longint   lo, hi, mid, x, v;
        int       lower, upper, sign, lvl;
        lo    = cal.cal_min;
        hi    = cal.cal_max;
        mid   = cal.cal_center;
        x     = s;
        lower = cal.dig_lower;
        upper = cal.dig_upper;
        sign  = (lower > upper) ? -1 : 1;
        if ((x > lower && x < upper) || (x > upper && x < lower))
        begin
            lvl = 0;
        end
        else if (x > upper)
        begin
            lvl = sign;
        end
        else if (x < lower)
        begin
            lvl = -sign;
        end
        else
        begin
            lvl = 0;
        end
        if (cal.output_mode)
        begin
            v = lvl * OUT_MAX;
        end
        else if (x == mid)
        begin
            v = OUT_CENTER;
        end
        else if ((x < mid && lo <= hi) || (x > mid && lo > hi))
        begin
            v = segment(x, lo, mid, OUT_MIN, OUT_CENTER);
        end
        else
        begin
            v = segment(x, mid, hi, OUT_CENTER, OUT_MAX);
        end
        if (v < OUT_MIN)
        begin
            v = OUT_MIN;
        end
        if (v > OUT_MAX)
        begin
            v = OUT_MAX;
        end
        if (v < -FIELD_LIMIT)
        begin
            v = -FIELD_LIMIT;
        end
        if (v > FIELD_LIMIT)
        begin
            v = FIELD_LIMIT;
        end
        r.changed   = (s != last_sample);
        r.axis      = AXIS_W'(v);
        r.level     = LEVEL_W'(lvl);
        last_sample = s;
        return r;
    endfunction

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [REG_W-1:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return REG_W'($urandom_range(0, SAMPLE_TOP));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t             c;
        logic [REG_W-1:0] a, b, m, t;
        int               form;
        a    = pick_reg();
        b    = pick_reg();
        m    = pick_reg();
        form = $urandom_range(0, 2);
        // mostly a well-ordered min/center/max, ascending or inverted
        if (form != 0)
        begin
            if (a > m)
            begin
                t = a; a = m; m = t;
            end
            if (m > b)
            begin
                t = m; m = b; b = t;
            end
            if (a > m)
            begin
                t = a; a = m; m = t;
            end
            if (form == 2)
            begin
                t = a; a = b; b = t;
            end
        end
        c.cal_min     = a;
        c.cal_max     = b;
        c.cal_center  = m;
        c.dig_lower   = pick_reg();
        c.dig_upper   = pick_reg();
        c.output_mode = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // samples cluster on the center, thresholds and ends, with repeats
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom_range(0, SAMPLE_TOP);
            3:       v = last_sample;
            4:       v = int'(cal.cal_center) + $urandom_range(0, 6) - 3;
            5:       v = int'(cal.dig_lower) + $urandom_range(0, 4) - 2;
            6:       v = int'(cal.dig_upper) + $urandom_range(0, 4) - 2;
            default: v = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : SAMPLE_TOP - $urandom_range(0, 3);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > SAMPLE_TOP)
        begin
            v = SAMPLE_TOP;
        end
        return SAMPLE_W'(v);
    endfunction

    task automatic add_row(input cfg_t c, input int s, input bit typed,
                           input bit ch, input int ax, input int lv);
        vector_t row;
        row.setting      = c;
        row.sample       = SAMPLE_W'(s);
        row.typed        = typed;
        row.want.changed = ch;
        row.want.axis    = AXIS_W'(ax);
        row.want.level   = LEVEL_W'(lv);
        directed.push_back(row);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input reading_t typed_want);
        int       gap;
        reading_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(s);
        do @(posedge clk); while (!s_tready);
        predicted = calibrate(s);
        pending_readings.push_back(typed ? typed_want : predicted);
        samples_sent++;
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CAL_MIN:     cal.cal_min     = data;
            CFG_CAL_MAX:     cal.cal_max     = data;
            CFG_CAL_CENTER:  cal.cal_center  = data;
            CFG_DIG_LOWER:   cal.dig_lower   = data;
            CFG_DIG_UPPER:   cal.dig_upper   = data;
            CFG_OUTPUT_MODE: cal.output_mode = data[0];
            default:         ;
        endcase
    endtask

    task automatic load_calibration(input cfg_t c);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_CAL_MIN, c.cal_min);
        write_reg(CFG_CAL_MAX, c.cal_max);
        write_reg(CFG_CAL_CENTER, c.cal_center);
        write_reg(CFG_DIG_LOWER, c.dig_lower);
        write_reg(CFG_DIG_UPPER, c.dig_upper);
        // output_mode data carries random upper bits that must be dropped
        write_reg(CFG_OUTPUT_MODE,
                  {(REG_W-1)'($urandom_range(0, SAMPLE_TOP)), c.output_mode});
        if ($urandom_range(0, 1))
        begin
            write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                      REG_W'($urandom_range(0, SAMPLE_TOP)));
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // result side: random stall, then take one reading and check it
    initial
    begin
        reading_t got;
        reading_t want;
        int       stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.changed = m_tuser;
            got.axis    = m_tdata[AXIS_W-1:0];
            got.level   = m_tdata[AXIS_W +: LEVEL_W];
            if (pending_readings.size() == 0)
            begin
                $error("reading returned with no request pending");
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (got.changed !== want.changed)
                begin
                    $error("changed: expected %0d, got %0d", want.changed, got.changed);
                    mismatches++;
                end
                if (got.axis !== want.axis)
                begin
                    $error("axis_value: expected %0d, got %0d", want.axis, got.axis);
                    mismatches++;
                end
                if (got.level !== want.level)
                begin
                    $error("digital_state: expected %0d, got %0d", want.level, got.level);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cfg_t c;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        cal         = CFG_RST;
        last_sample = PREV_RST;

        // reset defaults: ends, center and thresholds
        c = CFG_RST;
        add_row(c, 1, 1, 1'b0, -32752, -1);
        add_row(c, 0, 1, 1'b1, -32767, -1);
        add_row(c, 4095, 1, 1'b1, 32767, 1);
        add_row(c, 2048, 1, 1'b1, 0, 0);
        add_row(c, 1024, 0, 0, 0, 0);
        add_row(c, 3072, 0, 0, 0, 0);
        add_row(c, 1023, 0, 0, 0, 0);
        // inverted axis, samples outside the calibrated span saturate
        c.cal_min    = 12'd4000;
        c.cal_max    = 12'd100;
        c.cal_center = 12'd2000;
        add_row(c, 4095, 0, 0, 0, 0);
        add_row(c, 0, 0, 0, 0, 0);
        add_row(c, 2000, 0, 0, 0, 0);
        add_row(c, 1000, 0, 0, 0, 0);
        // zero-width lower segment, then zero-width upper segment
        c.cal_min    = 12'd1500;
        c.cal_max    = 12'd3500;
        c.cal_center = 12'd1500;
        add_row(c, 100, 1, 1'b1, 0, -1);
        add_row(c, 3500, 0, 0, 0, 0);
        c.cal_min    = 12'd500;
        c.cal_max    = 12'd3000;
        c.cal_center = 12'd3000;
        add_row(c, 4000, 0, 0, 0, 0);
        // digital mode with inverted thresholds
        c = CFG_RST;
        c.output_mode = 1'b1;
        c.dig_lower   = 12'd3000;
        c.dig_upper   = 12'd1000;
        add_row(c, 2000, 1, 1'b1, 0, 0);
        add_row(c, 4095, 1, 1'b1, -32767, -1);
        add_row(c, 0, 1, 1'b1, 32767, 1);
        add_row(c, 3000, 0, 0, 0, 0);
        add_row(c, 1000, 0, 0, 0, 0);
        // equal thresholds
        c.dig_lower = 12'd2000;
        c.dig_upper = 12'd2000;
        add_row(c, 2000, 0, 0, 0, 0);
        add_row(c, 2001, 0, 0, 0, 0);
        add_row(c, 1999, 0, 0, 0, 0);
        // digital mode, default thresholds, repeated sample
        c = CFG_RST;
        c.output_mode = 1'b1;
        add_row(c, 4095, 1, 1'b1, 32767, 1);
        add_row(c, 0, 1, 1'b1, -32767, -1);
        add_row(c, 0, 1, 1'b0, -32767, -1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].setting != cal)
            begin
                load_calibration(directed[i].setting);
            end
            send_sample(directed[i].sample, directed[i].typed, directed[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_calibration(random_setting());
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (PHASE_SAMPLES) send_sample(pick_sample(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples sent, %0d readings checked, %0d calibration settings loaded",
                 samples_sent, readings_checked, settings_loaded);
        $display("linear and digital modes, inverted axes and thresholds, random stalls");
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
